[hw/rtl/scgb_pkg.sv]
// Shared types, reply text tables and character constants for the serial GPIO bridge.
`default_nettype none

package scgb_pkg;

   // Parse position within a three-byte command
   typedef enum logic [1:0] {
      PH_CMD  = 2'd0,
      PH_PORT = 2'd1,
      PH_PIN  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      PORT_NONE = 2'd0,
      PORT_B    = 2'd1,
      PORT_C    = 2'd2,
      PORT_D    = 2'd3
   } port_type;

   typedef enum logic [2:0] {
      MSG_NONE     = 3'd0,
      MSG_BAD_PORT = 3'd1,
      MSG_BAD_PIN  = 3'd2,
      MSG_OPEN     = 3'd3,
      MSG_CLOSED   = 3'd4,
      MSG_WHAT     = 3'd5
   } msg_type;

   typedef struct packed {
      logic [7:0] dir_b;
      logic [7:0] level_b;
      logic [7:0] dir_c;
      logic [7:0] level_c;
      logic [7:0] dir_d;
      logic [7:0] level_d;
   } port_regs_type;

   // One reply job: up to two texts, port registers as they stand after the item
   typedef struct packed {
      msg_type       msg_a;
      msg_type       msg_b;
      port_regs_type regs;
   } job_type;

   localparam int JOB_QUEUE_DEPTH = 2;
   localparam int JOB_QUEUE_AW    = $clog2(JOB_QUEUE_DEPTH);

   localparam logic [7:0] CH_E_UP   = "E";
   localparam logic [7:0] CH_E_LO   = "e";
   localparam logic [7:0] CH_A_UP   = "A";
   localparam logic [7:0] CH_A_LO   = "a";
   localparam logic [7:0] CH_L_UP   = "L";
   localparam logic [7:0] CH_L_LO   = "l";
   localparam logic [7:0] CH_B_UP   = "B";
   localparam logic [7:0] CH_B_LO   = "b";
   localparam logic [7:0] CH_C_UP   = "C";
   localparam logic [7:0] CH_C_LO   = "c";
   localparam logic [7:0] CH_D_UP   = "D";
   localparam logic [7:0] CH_D_LO   = "d";
   localparam logic [7:0] CH_PIN_LO = "1";
   localparam logic [7:0] CH_PIN_HI = "7";

   localparam logic [0:15][7:0] TXT_BAD_PORT = "invalid port! \n\r";
   localparam logic [0:14][7:0] TXT_BAD_PIN  = "invalid pin! \n\r";
   localparam logic [0:7][7:0]  TXT_OPEN     = "offen \n\r";
   localparam logic [0:4][7:0]  TXT_CLOSED   = "zu \n\r";
   localparam logic [0:12][7:0] TXT_WHAT     = "wie bitte? \n\r";

   // Index of the final character of a text
   function automatic logic [3:0] msg_last(input msg_type msg);
      logic [3:0] last;
      case (msg)
         MSG_BAD_PORT: last = 4'd15;
         MSG_BAD_PIN:  last = 4'd14;
         MSG_OPEN:     last = 4'd7;
         MSG_CLOSED:   last = 4'd4;
         MSG_WHAT:     last = 4'd12;
         default:      last = 4'd0;
      endcase
      return last;
   endfunction

   function automatic logic [7:0] msg_char(input msg_type msg, input logic [3:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      case (msg)
         MSG_BAD_PORT: ch = TXT_BAD_PORT[idx];
         MSG_BAD_PIN: begin
            if (idx <= 4'd14) ch = TXT_BAD_PIN[idx];
         end
         MSG_OPEN:     ch = TXT_OPEN[idx[2:0]];
         MSG_CLOSED: begin
            if (idx <= 4'd4) ch = TXT_CLOSED[idx[2:0]];
         end
         MSG_WHAT: begin
            if (idx <= 4'd12) ch = TXT_WHAT[idx];
         end
         default:      ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/scgb_req_if.sv]
// Request channel: received character plus sampled port pin levels.
`default_nettype none

interface scgb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [7:0] pins_b;
   logic [7:0] pins_c;
   logic [7:0] pins_d;

   modport source (output valid, output rx_byte, output pins_b, output pins_c,
                   output pins_d, input ready);
   modport sink   (input valid, input rx_byte, input pins_b, input pins_c,
                   input pins_d, output ready);
endinterface

`default_nettype wire

[hw/rtl/scgb_rsp_if.sv]
// Response channel: reply character and current port register image.
`default_nettype none

interface scgb_rsp_if;
   logic       valid;
   logic       ready;
   logic       reply_valid;
   logic [7:0] reply_byte;
   logic       reply_last;
   logic [7:0] dir_b;
   logic [7:0] level_b;
   logic [7:0] dir_c;
   logic [7:0] level_c;
   logic [7:0] dir_d;
   logic [7:0] level_d;

   modport source (output valid, output reply_valid, output reply_byte, output reply_last,
                   output dir_b, output level_b, output dir_c, output level_c,
                   output dir_d, output level_d, input ready);
   modport sink   (input valid, input reply_valid, input reply_byte, input reply_last,
                   input dir_b, input level_b, input dir_c, input level_c,
                   input dir_d, input level_d, output ready);
endinterface

`default_nettype wire

[hw/rtl/scgb_front.sv]
// Front end: command parser, port register update and reply job generation.
`default_nettype none

module scgb_front import scgb_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   scgb_req_if.sink req_chan,
   input  logic   q_full,
   output logic   q_push,
   output job_type q_push_data
);

   phase_type     phase_ff, phase_in;
   logic [7:0]    held_cmd_ff, held_cmd_in;
   port_type      held_port_ff, held_port_in;
   port_regs_type regs_ff, regs_in;

   logic          accept;
   port_type      port_dec;
   logic          pin_ok, cmd_set, cmd_clr, cmd_in, do_update;
   logic [7:0]    pin_bit, sel_dir, sel_lvl, sel_pins, new_dir, new_lvl;
   msg_type       msg_first, msg_second;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_chan.rx_byte == CH_B_UP || req_chan.rx_byte == CH_B_LO) begin
         port_dec = PORT_B;
      end else if (req_chan.rx_byte == CH_C_UP || req_chan.rx_byte == CH_C_LO) begin
         port_dec = PORT_C;
      end else if (req_chan.rx_byte == CH_D_UP || req_chan.rx_byte == CH_D_LO) begin
         port_dec = PORT_D;
      end else begin
         port_dec = PORT_NONE;
      end
   end

   assign pin_ok  = (req_chan.rx_byte >= CH_PIN_LO) && (req_chan.rx_byte <= CH_PIN_HI);
   assign cmd_set = (held_cmd_ff == CH_E_UP) || (held_cmd_ff == CH_E_LO);
   assign cmd_clr = (held_cmd_ff == CH_A_UP) || (held_cmd_ff == CH_A_LO);
   assign cmd_in  = (held_cmd_ff == CH_L_UP) || (held_cmd_ff == CH_L_LO);
   // '1'..'7' map onto bit positions through the low three bits
   assign pin_bit = 8'b1 << req_chan.rx_byte[2:0];
   assign do_update = (cmd_set || cmd_clr || cmd_in) && pin_ok && (held_port_ff != PORT_NONE);

   always_comb begin
      case (held_port_ff)
         PORT_B: begin
            sel_dir  = regs_ff.dir_b;
            sel_lvl  = regs_ff.level_b;
            sel_pins = req_chan.pins_b;
         end
         PORT_C: begin
            sel_dir  = regs_ff.dir_c;
            sel_lvl  = regs_ff.level_c;
            sel_pins = req_chan.pins_c;
         end
         PORT_D: begin
            sel_dir  = regs_ff.dir_d;
            sel_lvl  = regs_ff.level_d;
            sel_pins = req_chan.pins_d;
         end
         default: begin
            sel_dir  = 8'h00;
            sel_lvl  = 8'h00;
            sel_pins = 8'h00;
         end
      endcase
   end

   always_comb begin
      new_dir = sel_dir;
      new_lvl = sel_lvl;
      if (cmd_set) begin
         new_dir = sel_dir | pin_bit;
         new_lvl = sel_lvl | pin_bit;
      end else if (cmd_clr) begin
         new_dir = sel_dir | pin_bit;
         new_lvl = sel_lvl & ~pin_bit;
      end else begin
         new_dir = sel_dir & ~pin_bit;
         new_lvl = sel_lvl | pin_bit;
      end
   end

   always_comb begin
      msg_first  = pin_ok ? MSG_NONE : MSG_BAD_PIN;
      msg_second = MSG_NONE;
      if (!(cmd_set || cmd_clr || cmd_in)) begin
         msg_second = MSG_WHAT;
      end else if (cmd_in && do_update) begin
         msg_second = ((sel_pins & pin_bit) != 8'h00) ? MSG_OPEN : MSG_CLOSED;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      held_cmd_in  = held_cmd_ff;
      held_port_in = held_port_ff;
      regs_in      = regs_ff;
      q_push       = 1'b0;
      q_push_data  = '{msg_a: MSG_NONE, msg_b: MSG_NONE, regs: regs_ff};
      if (accept) begin
         case (phase_ff)
            PH_PORT: begin
               held_port_in = port_dec;
               phase_in     = PH_PIN;
               if (port_dec == PORT_NONE) begin
                  q_push            = 1'b1;
                  q_push_data.msg_a = MSG_BAD_PORT;
               end
            end
            PH_PIN: begin
               phase_in = PH_CMD;
               if (do_update) begin
                  case (held_port_ff)
                     PORT_B: begin
                        regs_in.dir_b   = new_dir;
                        regs_in.level_b = new_lvl;
                     end
                     PORT_C: begin
                        regs_in.dir_c   = new_dir;
                        regs_in.level_c = new_lvl;
                     end
                     PORT_D: begin
                        regs_in.dir_d   = new_dir;
                        regs_in.level_d = new_lvl;
                     end
                     default: begin
                        regs_in = regs_ff;
                     end
                  endcase
               end
               q_push           = 1'b1;
               q_push_data.regs = regs_in;
               // keep the first slot filled when only one text goes out
               if (msg_first == MSG_NONE) begin
                  q_push_data.msg_a = msg_second;
                  q_push_data.msg_b = MSG_NONE;
               end else begin
                  q_push_data.msg_a = msg_first;
                  q_push_data.msg_b = msg_second;
               end
            end
            default: begin
               held_cmd_in = req_chan.rx_byte;
               phase_in    = PH_PORT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CMD;
         held_cmd_ff  <= 8'h00;
         held_port_ff <= PORT_NONE;
         regs_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         held_cmd_ff  <= held_cmd_in;
         held_port_ff <= held_port_in;
         regs_ff      <= regs_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/scgb_queue.sv]
// Small job queue between parser and reply sequencer.
`default_nettype none

module scgb_queue import scgb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   localparam logic [JOB_QUEUE_AW:0] DEPTH_CNT = (JOB_QUEUE_AW + 1)'(JOB_QUEUE_DEPTH);

   job_type                 mem_ff [JOB_QUEUE_DEPTH];
   logic [JOB_QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_QUEUE_AW:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == JOB_QUEUE_AW'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == JOB_QUEUE_AW'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/scgb_back.sv]
// Back end: reply texts to response register, one char per cycle unless stalled.
`default_nettype none

module scgb_back import scgb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_data,
   output logic    q_pop,
   scgb_rsp_if.source rsp_chan
);

   logic          busy_ff, busy_in;
   job_type       job_ff, job_in;
   logic          seg_ff, seg_in;
   logic [3:0]    idx_ff, idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_rvalid_ff, out_rvalid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;
   port_regs_type out_regs_ff, out_regs_in;

   logic          advance, emit, blank, seg_end, job_end;
   msg_type       cur_msg;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign emit    = busy_ff && advance;
   assign cur_msg = seg_ff ? job_ff.msg_b : job_ff.msg_a;
   // a job with no text still owes one blank result
   assign blank   = (job_ff.msg_a == MSG_NONE);
   assign seg_end = blank || (idx_ff == msg_last(cur_msg));
   assign job_end = seg_end && (seg_ff || job_ff.msg_b == MSG_NONE);
   assign q_pop   = !q_empty && (!busy_ff || (emit && job_end));

   always_comb begin
      busy_in = busy_ff;
      job_in  = job_ff;
      seg_in  = seg_ff;
      idx_in  = idx_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         job_in  = q_data;
         seg_in  = 1'b0;
         idx_in  = '0;
      end else if (emit && job_end) begin
         busy_in = 1'b0;
      end else if (emit) begin
         if (seg_end) begin
            seg_in = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_rvalid_in = out_rvalid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_regs_in   = out_regs_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         out_rvalid_in = !blank;
         out_byte_in   = blank ? 8'h00 : msg_char(cur_msg, idx_ff);
         out_last_in   = job_end;
         out_regs_in   = job_ff.regs;
      end else if (rsp_chan.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         seg_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      out_rvalid_ff <= out_rvalid_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_regs_ff   <= out_regs_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.reply_valid = out_rvalid_ff;
   assign rsp_chan.reply_byte  = out_byte_ff;
   assign rsp_chan.reply_last  = out_last_ff;
   assign rsp_chan.dir_b       = out_regs_ff.dir_b;
   assign rsp_chan.level_b     = out_regs_ff.level_b;
   assign rsp_chan.dir_c       = out_regs_ff.dir_c;
   assign rsp_chan.level_c     = out_regs_ff.level_c;
   assign rsp_chan.dir_d       = out_regs_ff.dir_d;
   assign rsp_chan.level_d     = out_regs_ff.level_d;

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job popped from empty queue");

   a_idx_in_text: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !blank) |-> (idx_ff <= msg_last(cur_msg)))
      else $error("character index past end of text");

   a_blank_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_rvalid_ff) |-> out_last_ff)
      else $error("blank result not marked last");

   a_emit_loads_output: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted character lost");
`endif

endmodule

`default_nettype wire

[hw/rtl/serial_command_gpio_bridge_top.sv]
// Top level of the serial command to GPIO bridge.
//
//  channel   dir  handshake           payload
//  req_chan  in   valid/ready         rx_byte, pins_b, pins_c, pins_d
//  rsp_chan  out  valid/ready         reply_valid, reply_byte, reply_last,
//                                     dir_b, level_b, dir_c, level_c, dir_d, level_d
//
// Cycles: one item is taken per cycle while the job queue has room. Each reply
// character passes through the back-end sequencer, so a pin item yields one blank
// result or up to two texts; an idle sequencer first loads a job into its job register.
// Reset: synchronous, active high; parse phase, held command/port and all port
// registers clear to zero.
// Stalls: a stalled response holds the sequencer; the front keeps parsing until the
// two-entry job queue fills, then drops req_chan.ready.
`default_nettype none

module serial_command_gpio_bridge_top import scgb_pkg::*; (
   input  logic clock,
   input  logic reset,
   scgb_req_if.sink   req_chan,
   scgb_rsp_if.source rsp_chan
);

   logic    q_push, q_full, q_pop, q_empty;
   job_type q_push_data, q_pop_data;

   // Parser: tracks command/port/pin phase, owns port registers, emits jobs
   scgb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // Decouples parsing from the character-rate reply stream
   scgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // Sequencer: one reply character per cycle into the response register while rsp_chan is ready
   scgb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
